// ----- src/abpl_pkg.sv -----
`timescale 1ns / 1ps

package abpl_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MAX_BINS_DEF        = 4096;
  localparam int unsigned LOG_TABLE_SIZE_DEF  = 256;
  localparam int unsigned SINE_TABLE_SIZE_DEF = 1024;

  // Field and register widths.
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned HZ_W      = 17;
  localparam int unsigned SPACING_W = 33;
  localparam int unsigned THR_W     = 9;
  localparam int unsigned OSC_W     = 10;
  localparam int unsigned FR_W      = 24;
  localparam int unsigned RUN_W     = 32;
  localparam int unsigned CFG_W     = 33;
  localparam int unsigned CFG_IDX_W = 3;

  // Fraction bits of the Q17.16 band limits and of the phase numerator.
  localparam int unsigned FRAC_W = 16;

  // Phase product (oscillation rate times run count) and divider widths.
  localparam int unsigned PHASE_W   = OSC_W + RUN_W;
  localparam int unsigned DIV_W     = PHASE_W + FRAC_W;
  localparam int unsigned DIVISOR_W = FR_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_LOW   = 3'd0,
    CFG_BAND_HIGH  = 3'd1,
    CFG_BIN_SPACE  = 3'd2,
    CFG_THRESHOLD  = 3'd3,
    CFG_OSC_HZ     = 3'd4,
    CFG_FRAME_RATE = 3'd5
  } cfg_reg_e;

  // Input request payload.
  typedef struct packed {
    logic [MAG_W-1:0] bin_magnitude;
    logic             last_bin;
    logic             window_full;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic signed [LEVEL_W-1:0] light_level;
    logic                      above_threshold;
  } out_t;

  // Commands to the bin tracker.
  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } bins_ctl_t;

  // Divider request and response.
  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- src/abpl_div.sv -----
`timescale 1ns / 1ps

module abpl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abpl_pkg::div_req_t  req_i,
  output abpl_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned DW    = abpl_pkg::DIV_W;
  localparam int unsigned SW    = abpl_pkg::DIVISOR_W;
  localparam int unsigned CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);

  logic [DW-1:0]    dvd_q, dvd_d;
  logic [SW-1:0]    dsr_q;
  logic [SW-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [SW:0]      trial, diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? diff[SW-1:0] : trial[SW-1:0];
    dvd_d = {dvd_q[DW-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand registers; the dividend register fills with quotient bits.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- src/abpl_bins.sv -----
`timescale 1ns / 1ps

module abpl_bins #(
  parameter int unsigned MAX_BINS = abpl_pkg::MAX_BINS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  abpl_pkg::bins_ctl_t              ctl_i,
  input  logic [abpl_pkg::MAG_W-1:0]       mag_i,
  input  logic [abpl_pkg::HZ_W-1:0]        band_low_i,
  input  logic [abpl_pkg::HZ_W-1:0]        band_high_i,
  input  logic [abpl_pkg::SPACING_W-1:0]   spacing_i,
  output logic [abpl_pkg::MAG_W-1:0]       peak_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned FREQ_W = abpl_pkg::SPACING_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BINS);

  logic [CNT_W-1:0]           counter_q;
  logic [abpl_pkg::MAG_W-1:0] peak_q;
  logic [abpl_pkg::MAG_W-1:0] mag_q;
  logic [FREQ_W-1:0]          freq_q;
  logic [FREQ_W-1:0]          low_lim, high_lim;
  logic                       in_band;

  // Band limits in Q17.16 against the bin frequency.
  always_comb begin
    low_lim  = FREQ_W'({band_low_i, {abpl_pkg::FRAC_W{1'b0}}});
    high_lim = FREQ_W'({band_high_i, {abpl_pkg::FRAC_W{1'b0}}});
    in_band  = (freq_q >= low_lim) && (freq_q <= high_lim);
  end

  // Bin frequency and magnitude are captured with the request.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      freq_q <= FREQ_W'(spacing_i) * FREQ_W'(counter_q);
      mag_q  <= mag_i;
    end
  end

  // Peak tracking and bin counting; the counter holds past the last bin slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      peak_q    <= '0;
    end else if (ctl_i.clear) begin
      counter_q <= '0;
      peak_q    <= '0;
    end else if (ctl_i.step && (counter_q < CNT_LIMIT)) begin
      counter_q <= counter_q + 1'b1;
      if (in_band && (mag_q > peak_q)) begin
        peak_q <= mag_q;
      end
    end
  end

  assign peak_o = peak_q;

endmodule

// ----- src/audio_band_peak_light_level.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake                  Payload
// cfg      in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
// in       in   in_valid_i / in_stall_o    abpl_pkg::in_t (one FFT bin)
// out      out  out_valid_o / out_stall_i  abpl_pkg::out_t (one result per frame)
//
// A bin that does not end a frame passes the request in ST_IDLE, then the band compare in ST_BIN.
// A last bin then runs the frame steps up to the result. The shared 58-step
// divider does the level, phase modulo and sine index divisions, after up to 23 single-bit
// normalize steps.
// rst_ni clears the sequencer, bin counter, peak and run counter and loads register defaults.
// A result waits in the output register while out_stall_i is high; the next request is
// taken meanwhile, and a frame end waits in its last step until that register is free.

module audio_band_peak_light_level #(
  parameter int unsigned MAX_BINS        = abpl_pkg::MAX_BINS_DEF,
  parameter int unsigned LOG_TABLE_SIZE  = abpl_pkg::LOG_TABLE_SIZE_DEF,
  parameter int unsigned SINE_TABLE_SIZE = abpl_pkg::SINE_TABLE_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [abpl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [abpl_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  abpl_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output abpl_pkg::out_t                   out_data_o
);

  localparam int unsigned MAG_W   = abpl_pkg::MAG_W;
  localparam int unsigned LEVEL_W = abpl_pkg::LEVEL_W;
  localparam int unsigned DIV_W   = abpl_pkg::DIV_W;
  localparam int unsigned PHASE_W = abpl_pkg::PHASE_W;
  localparam int unsigned LOG_AW  = $clog2(LOG_TABLE_SIZE);
  localparam int unsigned LOGP_W  = (MAG_W - 1) + $clog2(LOG_TABLE_SIZE + 1);
  localparam int unsigned SIN_AW  = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned SCALE_W = abpl_pkg::FR_W + $clog2(SINE_TABLE_SIZE + 1);

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [19:0] DB_K = 20'sd394566;
  localparam logic [4:0] E_TOP = 5'(MAG_W - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h7FFF;

  localparam logic [abpl_pkg::HZ_W-1:0]      BAND_LOW_RST  = 17'd20;
  localparam logic [abpl_pkg::HZ_W-1:0]      BAND_HIGH_RST = 17'd20000;
  localparam logic [abpl_pkg::SPACING_W-1:0] SPACING_RST   = 33'd1536000;
  localparam logic [abpl_pkg::THR_W-1:0]     THR_RST       = 9'h1E2;
  localparam logic [abpl_pkg::OSC_W-1:0]     OSC_RST       = 10'd5;
  localparam logic [abpl_pkg::FR_W-1:0]      FR_RST        = 24'd1638400;

  // log2(1 + i/N) in Q16, built by repeated Q30 squaring.
  function automatic logic [LOG_TABLE_SIZE*16-1:0] log_rom_gen();
    logic [LOG_TABLE_SIZE*16-1:0] rom;
    logic [63:0] x;
    logic [15:0] r;
    int          i;
    int          k;
    rom = '0;
    for (i = 0; i < LOG_TABLE_SIZE; i++) begin
      x = ONE_Q30 + ((64'(i) << 30) / LOG_TABLE_SIZE);
      r = '0;
      for (k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = {r[14:0], 1'b0};
        if (x >= (ONE_Q30 << 1)) begin
          r[0] = 1'b1;
          x    = x >> 1;
        end
      end
      rom[i*16 +: 16] = r;
    end
    return rom;
  endfunction

  // sin(2*pi*i/N) in Q1.15 from a Q30 Taylor series on the first quadrant.
  function automatic logic [SINE_TABLE_SIZE*16-1:0] sine_rom_gen();
    logic [SINE_TABLE_SIZE*16-1:0] rom;
    logic [63:0] u;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [1:0]  q;
    logic [15:0] v;
    int          i;
    rom = '0;
    for (i = 0; i < SINE_TABLE_SIZE; i++) begin
      u = (64'(i) << 32) / SINE_TABLE_SIZE;
      q = u[31:30];
      f = u & (ONE_Q30 - 64'd1);
      if (q[0]) begin
        f = ONE_Q30 - f;
      end
      x  = (f * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      v = s[15:0];
      if (q[1]) begin
        v = -v;
      end
      rom[i*16 +: 16] = v;
    end
    return rom;
  endfunction

  localparam logic [LOG_TABLE_SIZE*16-1:0]  LOG_ROM  = log_rom_gen();
  localparam logic [SINE_TABLE_SIZE*16-1:0] SINE_ROM = sine_rom_gen();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIN,
    ST_PEAK,
    ST_NORM,
    ST_LOGMUL,
    ST_THR,
    ST_LVLDIV,
    ST_OSC,
    ST_MODGO,
    ST_MODDIV,
    ST_IDXGO,
    ST_IDXDIV,
    ST_OSCMUL,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [abpl_pkg::HZ_W-1:0]      band_low_q, band_high_q;
  logic [abpl_pkg::SPACING_W-1:0] spacing_q;
  logic [abpl_pkg::THR_W-1:0]     thr_q;
  logic [abpl_pkg::OSC_W-1:0]     osc_q;
  logic [abpl_pkg::FR_W-1:0]      fr_q;

  // Frame datapath.
  logic                      last_q, full_q;
  logic [MAG_W-1:0]          mant_q;
  logic [4:0]                e_q;
  logic [15:0]               log_q;
  logic signed [41:0]        dbp_q;
  logic signed [LEVEL_W-1:0] level_q;
  logic signed [LEVEL_W-1:0] sine_q;
  logic                      above_q;
  logic [PHASE_W-1:0]        phase_q;
  logic [SCALE_W-1:0]        scaled_q;
  logic [abpl_pkg::RUN_W-1:0] run_q;
  logic                      out_valid_q;
  abpl_pkg::out_t            out_data_q;

  logic                      in_accept;
  logic                      out_load;
  abpl_pkg::bins_ctl_t       bins_ctl;
  logic [MAG_W-1:0]          bins_peak;
  logic [MAG_W-1:0]          peak_sel;
  logic [LOGP_W-1:0]         log_prod;
  logic [LOG_AW-1:0]         log_idx;
  logic [5:0]                e_m20;
  logic signed [21:0]        lg2_val;
  logic signed [41:0]        db_prod;
  logic signed [17:0]        db_val, thr256, num, den;
  logic                      above_now;
  logic                      thr_neg;
  logic [LEVEL_W-1:0]        lvl_sat;
  logic [PHASE_W-1:0]        phase_prod;
  logic [SCALE_W-1:0]        scaled_prod;
  logic [SIN_AW-1:0]         sine_idx;
  logic signed [31:0]        osc_prod;
  abpl_pkg::div_req_t        div_req;
  abpl_pkg::div_rsp_t        div_rsp;

  // Handshakes.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
      spacing_q   <= SPACING_RST;
      thr_q       <= THR_RST;
      osc_q       <= OSC_RST;
      fr_q        <= FR_RST;
    end else if (cfg_we_i) begin
      unique case (abpl_pkg::cfg_reg_e'(cfg_idx_i))
        abpl_pkg::CFG_BAND_LOW:   band_low_q  <= cfg_wdata_i[abpl_pkg::HZ_W-1:0];
        abpl_pkg::CFG_BAND_HIGH:  band_high_q <= cfg_wdata_i[abpl_pkg::HZ_W-1:0];
        abpl_pkg::CFG_BIN_SPACE:  spacing_q   <= cfg_wdata_i[abpl_pkg::SPACING_W-1:0];
        abpl_pkg::CFG_THRESHOLD:  thr_q       <= cfg_wdata_i[abpl_pkg::THR_W-1:0];
        abpl_pkg::CFG_OSC_HZ:     osc_q       <= cfg_wdata_i[abpl_pkg::OSC_W-1:0];
        abpl_pkg::CFG_FRAME_RATE: fr_q        <= cfg_wdata_i[abpl_pkg::FR_W-1:0];
        default: ;
      endcase
    end
  end

  // Bin tracker commands.
  assign bins_ctl.load  = in_accept;
  assign bins_ctl.step  = (state_q == ST_BIN);
  assign bins_ctl.clear = (state_q == ST_PEAK);

  abpl_bins #(
    .MAX_BINS(MAX_BINS)
  ) u_bins (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (bins_ctl),
    .mag_i      (in_data_i.bin_magnitude),
    .band_low_i (band_low_q),
    .band_high_i(band_high_q),
    .spacing_i  (spacing_q),
    .peak_o     (bins_peak)
  );

  // Frame arithmetic between sequencer steps.
  always_comb begin
    peak_sel    = full_q ? bins_peak : '0;
    log_prod    = LOGP_W'(mant_q[MAG_W-2:0]) * LOGP_W'(LOG_TABLE_SIZE);
    log_idx     = log_prod[MAG_W-1 +: LOG_AW];
    e_m20       = 6'(e_q) - 6'd20;
    lg2_val     = {e_m20, log_q};
    db_prod     = lg2_val * DB_K;
    db_val      = dbp_q[41:24];
    thr256      = {thr_q[abpl_pkg::THR_W-1], thr_q, 8'b0};
    above_now   = (db_val >= thr256);
    thr_neg     = thr_q[abpl_pkg::THR_W-1];
    num         = db_val - thr256;
    den         = -thr256;
    lvl_sat     = (|div_rsp.quotient[DIV_W-1:LEVEL_W-1]) ? LEVEL_MAX
                                                          : 16'(div_rsp.quotient[LEVEL_W-2:0]);
    phase_prod  = PHASE_W'(osc_q) * PHASE_W'(run_q);
    scaled_prod = SCALE_W'(div_rsp.remainder) * SCALE_W'(SINE_TABLE_SIZE);
    sine_idx    = div_rsp.quotient[SIN_AW-1:0];
    osc_prod    = level_q * sine_q;
  end

  // Divider requests: level ratio, phase modulo, then sine index.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    priority if (state_q == ST_THR) begin
      div_req.start    = above_now && thr_neg;
      div_req.dividend = DIV_W'({num[16:0], 15'b0});
      div_req.divisor  = abpl_pkg::DIVISOR_W'(den[16:0]);
    end else if (state_q == ST_MODGO) begin
      div_req.start    = 1'b1;
      div_req.dividend = {phase_q, {abpl_pkg::FRAC_W{1'b0}}};
      div_req.divisor  = fr_q;
    end else if (state_q == ST_IDXGO) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(scaled_q);
      div_req.divisor  = fr_q;
    end else begin
      div_req.start    = 1'b0;
    end
  end

  abpl_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Sequencer, output valid and run counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      run_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        run_q       <= above_q ? run_q + 32'd1 : 32'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) state_q <= ST_BIN;
        end
        ST_BIN: begin
          state_q <= last_q ? ST_PEAK : ST_IDLE;
        end
        ST_PEAK: begin
          state_q <= (peak_sel == '0) ? ST_FINISH : ST_NORM;
        end
        ST_NORM: begin
          if (mant_q[MAG_W-1]) state_q <= ST_LOGMUL;
        end
        ST_LOGMUL: begin
          state_q <= ST_THR;
        end
        ST_THR: begin
          priority if (!above_now) begin
            state_q <= ST_FINISH;
          end else if (thr_neg) begin
            state_q <= ST_LVLDIV;
          end else begin
            state_q <= ST_OSC;
          end
        end
        ST_LVLDIV: begin
          if (div_rsp.done) state_q <= ST_OSC;
        end
        ST_OSC: begin
          state_q <= ((osc_q == '0) || (fr_q == '0)) ? ST_FINISH : ST_MODGO;
        end
        ST_MODGO: begin
          state_q <= ST_MODDIV;
        end
        ST_MODDIV: begin
          if (div_rsp.done) state_q <= ST_IDXGO;
        end
        ST_IDXGO: begin
          state_q <= ST_IDXDIV;
        end
        ST_IDXDIV: begin
          if (div_rsp.done) state_q <= ST_OSCMUL;
        end
        ST_OSCMUL: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Frame datapath registers, loaded step by step.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      last_q <= in_data_i.last_bin;
      full_q <= in_data_i.window_full;
    end
    unique case (state_q)
      ST_PEAK: begin
        mant_q  <= peak_sel;
        e_q     <= E_TOP;
        above_q <= 1'b0;
        level_q <= '0;
      end
      ST_NORM: begin
        // Shift until the leading one reaches the top, then read the log table.
        if (mant_q[MAG_W-1]) begin
          log_q <= LOG_ROM[log_idx*16 +: 16];
        end else begin
          mant_q <= {mant_q[MAG_W-2:0], 1'b0};
          e_q    <= e_q - 5'd1;
        end
      end
      ST_LOGMUL: begin
        dbp_q <= db_prod;
      end
      ST_THR: begin
        above_q <= above_now;
        level_q <= '0;
      end
      ST_LVLDIV: begin
        if (div_rsp.done) level_q <= lvl_sat;
      end
      ST_OSC: begin
        // With no frame rate the sine phase is zero, so the level drops to zero.
        if ((osc_q != '0) && (fr_q == '0)) level_q <= '0;
        phase_q <= phase_prod;
      end
      ST_MODDIV: begin
        if (div_rsp.done) scaled_q <= scaled_prod;
      end
      ST_IDXDIV: begin
        if (div_rsp.done) sine_q <= SINE_ROM[sine_idx*16 +: 16];
      end
      ST_OSCMUL: begin
        level_q <= osc_prod[30:15];
      end
      ST_FINISH: begin
        if (out_load) begin
          out_data_q.light_level     <= level_q;
          out_data_q.above_threshold <= above_q;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_below_is_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.above_threshold |-> out_data_o.light_level == '0)
    else $error("nonzero level below threshold");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NORM |-> mant_q != '0)
    else $error("normalizing a zero peak");

  a_run_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !above_q |=> run_q == 32'd1)
    else $error("run counter not restarted below threshold");
`endif

endmodule
